@@ rtl/core/pwct_pkg.sv @@
// Package for the pulse-width command transmitter.
// Holds the phase encoding, register indexes and the structs shared by the core modules.
// No dependencies.
`default_nettype none
package pwct_pkg;

	localparam int TICK_W = 16;
	localparam int CMD_W  = 8;
	localparam int IDX_W  = 2;

	// Register indexes on the configuration port
	localparam logic [IDX_W-1:0] REG_START_LOW = 2'd0;
	localparam logic [IDX_W-1:0] REG_LONG      = 2'd1;
	localparam logic [IDX_W-1:0] REG_SHORT     = 2'd2;
	localparam logic [IDX_W-1:0] REG_STOP_HIGH = 2'd3;

	localparam logic [TICK_W-1:0] START_LOW_RST = 16'd5000;
	localparam logic [TICK_W-1:0] LONG_RST      = 16'd1200;
	localparam logic [TICK_W-1:0] SHORT_RST     = 16'd400;
	localparam logic [TICK_W-1:0] STOP_HIGH_RST = 16'd100;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_SEND = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_START = 3'd1,
		PH_HIGH  = 3'd2,
		PH_LOW   = 3'd3,
		PH_STOP  = 3'd4
	} phase_t;

	typedef struct packed {
		logic [TICK_W-1:0] start_low;
		logic [TICK_W-1:0] long_len;
		logic [TICK_W-1:0] short_len;
		logic [TICK_W-1:0] stop_high;
	} cfg_t;

	typedef struct packed {
		logic line;
		logic busy;
		logic accepted;
		logic rejected;
		logic done;
	} res_t;

endpackage
`default_nettype wire

@@ rtl/core/pwct_cfg.sv @@
// Timing register file of the pulse-width command transmitter.
// Depends on pwct_pkg for register indexes, reset values and cfg_t.
`default_nettype none
module pwct_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [pwct_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [pwct_pkg::TICK_W-1:0] cfg_wdata,
	output pwct_pkg::cfg_t                  cfg
);
	import pwct_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_low <= START_LOW_RST;
			cfg_q.long_len  <= LONG_RST;
			cfg_q.short_len <= SHORT_RST;
			cfg_q.stop_high <= STOP_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_LOW: cfg_q.start_low <= cfg_wdata;
				REG_LONG:      cfg_q.long_len  <= cfg_wdata;
				REG_SHORT:     cfg_q.short_len <= cfg_wdata;
				REG_STOP_HIGH: cfg_q.stop_high <= cfg_wdata;
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

@@ rtl/core/pwct_engine.sv @@
// Transmit sequencer: phase, bit position, shift and tick counter registers.
// Depends on pwct_pkg for phase_t, cfg_t and res_t.
`default_nettype none
module pwct_engine #(
	parameter int BITS_PER_COMMAND = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      adv,
	input  wire logic                      kind,
	input  wire logic [pwct_pkg::CMD_W-1:0] command,
	input  wire pwct_pkg::cfg_t            cfg,
	output pwct_pkg::res_t                 res
);
	import pwct_pkg::*;

	localparam int BPW = $clog2(BITS_PER_COMMAND + 1);

	phase_t                  phase_q, phase_n;
	logic [BPW-1:0]          bit_pos_q, bit_pos_n, bit_pos_inc;
	logic [BITS_PER_COMMAND-1:0] shift_q, shift_n, shift_load;
	logic [TICK_W-1:0]       tick_q, tick_n, phase_len;
	logic [TICK_W:0]         count;
	logic                    line_q, line_n;
	logic                    acc_n, rej_n, done_n;

	always_comb begin
		shift_load = '0;
		for (int i = 0; i < BITS_PER_COMMAND; i++) begin
			if (i < CMD_W) shift_load[i] = command[i];
		end
	end

	always_comb begin
		case (phase_q)
			PH_START: phase_len = cfg.start_low;
			PH_HIGH:  phase_len = shift_q[0] ? cfg.long_len : cfg.short_len;
			PH_LOW:   phase_len = shift_q[0] ? cfg.short_len : cfg.long_len;
			default:  phase_len = cfg.stop_high;
		endcase
	end

	assign count       = {1'b0, tick_q} + {{TICK_W{1'b0}}, 1'b1};
	assign bit_pos_inc = bit_pos_q + BPW'(1);

	// Next state
	always_comb begin
		phase_n   = phase_q;
		bit_pos_n = bit_pos_q;
		shift_n   = shift_q;
		tick_n    = tick_q;
		line_n    = line_q;
		acc_n     = 1'b0;
		rej_n     = 1'b0;
		done_n    = 1'b0;
		if (kind == KIND_SEND) begin
			if (phase_q != PH_IDLE) begin
				rej_n = 1'b1;
			end else begin
				acc_n     = 1'b1;
				phase_n   = PH_START;
				bit_pos_n = '0;
				shift_n   = shift_load;
				tick_n    = '0;
				line_n    = 1'b0;
			end
		end else if (phase_q != PH_IDLE) begin
			if (count >= {1'b0, phase_len}) begin
				tick_n = '0;
				case (phase_q)
					PH_START: begin
						phase_n = PH_HIGH;
						line_n  = 1'b1;
					end
					PH_HIGH: begin
						phase_n = PH_LOW;
						line_n  = 1'b0;
					end
					PH_LOW: begin
						shift_n   = shift_q >> 1;
						bit_pos_n = bit_pos_inc;
						line_n    = 1'b1;
						phase_n   = (bit_pos_inc >= BPW'(BITS_PER_COMMAND)) ? PH_STOP : PH_HIGH;
					end
					default: begin
						phase_n   = PH_IDLE;
						bit_pos_n = '0;
						line_n    = 1'b1;
						done_n    = 1'b1;
					end
				endcase
			end else begin
				tick_n = count[TICK_W-1:0];
			end
		end
	end

	// Result word for this item
	always_comb begin
		res.line     = line_n;
		res.busy     = (phase_n != PH_IDLE);
		res.accepted = acc_n;
		res.rejected = rej_n;
		res.done     = done_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_pos_q <= '0;
			shift_q   <= '0;
			tick_q    <= '0;
			line_q    <= 1'b0;
		end else if (adv) begin
			phase_q   <= phase_n;
			bit_pos_q <= bit_pos_n;
			shift_q   <= shift_n;
			tick_q    <= tick_n;
			line_q    <= line_n;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/pulse_width_command_transmitter_top.sv @@
// Top level of the pulse-width command transmitter.
// Instantiates pwct_cfg and pwct_engine and holds the result register; uses pwct_pkg.
//
// One word enters per clock: each tick or send request is accepted in the cycle it is
// offered as long as the result register is empty or being drained, and its result word
// appears in the result register on the next clock. Sustained rate is one word per cycle
// while the consumer keeps out_ready high; a single result register lies on the path.
`default_nettype none
module pulse_width_command_transmitter_top #(
	parameter int BITS_PER_COMMAND = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [pwct_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [pwct_pkg::TICK_W-1:0] cfg_wdata,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       kind,
	input  wire logic [pwct_pkg::CMD_W-1:0]  command,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            line,
	output logic                            busy_res,
	output logic                            accepted,
	output logic                            rejected,
	output logic                            done_res
);
	import pwct_pkg::*;

	cfg_t cfg;
	res_t res;
	res_t res_q;
	logic out_valid_q;
	logic adv;

	assign in_ready = !out_valid_q || out_ready;
	assign adv      = in_valid && in_ready;

	pwct_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pwct_engine #(
		.BITS_PER_COMMAND (BITS_PER_COMMAND)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.kind    (kind),
		.command (command),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// Hold the result word while the consumer stalls
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign line      = res_q.line;
	assign busy_res  = res_q.busy;
	assign accepted  = res_q.accepted;
	assign rejected  = res_q.rejected;
	assign done_res  = res_q.done;

endmodule
`default_nettype wire

@@ rtl/core/pwct_checker.sv @@
// Port-level checker for the pulse-width command transmitter, bound to the top level.
// Watches the result channel only; no package dependency.
`default_nettype none
module pwct_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic                       line,
	input wire logic                       busy_res,
	input wire logic                       accepted,
	input wire logic                       rejected,
	input wire logic                       done_res
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(line) && $stable(busy_res))
		else $error("result word dropped or changed while stalled");

	a_send_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(accepted && rejected) && !(done_res && (accepted || rejected)))
		else $error("conflicting status flags in one result word");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> busy_res && !line)
		else $error("accepted send did not start low and busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res && line)
		else $error("stop period ended without idle high line");

	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> busy_res)
		else $error("send rejected while not busy");

endmodule

bind pulse_width_command_transmitter_top pwct_checker u_pwct_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.line      (line),
	.busy_res  (busy_res),
	.accepted  (accepted),
	.rejected  (rejected),
	.done_res  (done_res)
);
`default_nettype wire
